FILE: rtl/madf_pkg.sv
// Package for the MAC allow/deny list filter.
// Item kinds, field widths and default list depth; no dependencies.
`default_nettype none
package madf_pkg;
   localparam int LIST_DEPTH_DEF = 16;
   localparam int MAC_W          = 48;
   localparam int KIND_W         = 2;

   localparam logic [KIND_W-1:0] KIND_CHECK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOW = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DENY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   typedef struct packed {
      logic allow_wr;
      logic deny_wr;
      logic rd_en;
   } mem_ctrl_type;
endpackage
`default_nettype wire

FILE: rtl/madf_list_mem.sv
// One address list: single write port, one registered read port.
// Depends on madf_pkg for the entry width.
`default_nettype none
module madf_list_mem #(
   parameter int DEPTH = madf_pkg::LIST_DEPTH_DEF,
   parameter int IDX_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [IDX_W-1:0]           wr_addr,
   input  wire logic [madf_pkg::MAC_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [IDX_W-1:0]           rd_addr,
   output      logic [madf_pkg::MAC_W-1:0] rd_data
);
   logic [madf_pkg::MAC_W-1:0] mem [DEPTH];
   logic [madf_pkg::MAC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/madf_ctrl.sv
// Sequencer: list counts, add/clear handling, scan of both lists, result register.
// Depends on madf_pkg; drives two madf_list_mem instances.
`default_nettype none
module madf_ctrl #(
   parameter int LIST_DEPTH = madf_pkg::LIST_DEPTH_DEF,
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [madf_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [madf_pkg::MAC_W-1:0]   req_mac,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_filtered,
   output      logic                         rsp_status,
   output      madf_pkg::mem_ctrl_type       mem_ctrl,
   output      logic [IDX_W-1:0]             wr_addr,
   output      logic [IDX_W-1:0]             rd_addr,
   input  wire logic [madf_pkg::MAC_W-1:0]   allow_rd_data,
   input  wire logic [madf_pkg::MAC_W-1:0]   deny_rd_data
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [madf_pkg::MAC_W-1:0] mac_ff, mac_in;
   logic [CNT_W-1:0]           allow_cnt_ff, allow_cnt_in;
   logic [CNT_W-1:0]           deny_cnt_ff, deny_cnt_in;
   logic [IDX_W-1:0]           scan_idx_ff, scan_idx_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                       allow_hit_ff, allow_hit_in;
   logic                       deny_hit_ff, deny_hit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_filtered_ff, rsp_filtered_in;
   logic                       rsp_status_ff, rsp_status_in;

   logic take;
   logic allow_full, deny_full;
   logic cur_allow, cur_deny, allow_any, deny_any;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take       = req_valid && req_ready;
   assign allow_full = (allow_cnt_ff == CNT_W'(LIST_DEPTH));
   assign deny_full  = (deny_cnt_ff == CNT_W'(LIST_DEPTH));

   // only entries below the list count take part
   assign cur_allow = cmp_vld_ff && (CNT_W'(cmp_idx_ff) < allow_cnt_ff)
                      && (allow_rd_data == mac_ff);
   assign cur_deny  = cmp_vld_ff && (CNT_W'(cmp_idx_ff) < deny_cnt_ff)
                      && (deny_rd_data == mac_ff);
   assign allow_any = allow_hit_ff || cur_allow;
   assign deny_any  = deny_hit_ff || cur_deny;

   assign rd_addr = scan_idx_ff;
   assign wr_addr = (req_kind == madf_pkg::KIND_ALLOW) ? allow_cnt_ff[IDX_W-1:0]
                                                        : deny_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in        = state_ff;
      mac_in          = mac_ff;
      allow_cnt_in    = allow_cnt_ff;
      deny_cnt_in     = deny_cnt_ff;
      scan_idx_in     = scan_idx_ff;
      cmp_vld_in      = cmp_vld_ff;
      cmp_idx_in      = cmp_idx_ff;
      allow_hit_in    = allow_hit_ff;
      deny_hit_in     = deny_hit_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_status_in   = rsp_status_ff;
      mem_ctrl        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_kind)
                  madf_pkg::KIND_CHECK: begin
                     mac_in       = req_mac;
                     scan_idx_in  = '0;
                     cmp_vld_in   = 1'b0;
                     allow_hit_in = 1'b0;
                     deny_hit_in  = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  madf_pkg::KIND_ALLOW: begin
                     rsp_valid_in    = 1'b1;
                     rsp_filtered_in = 1'b0;
                     rsp_status_in   = allow_full;
                     if (!allow_full) begin
                        mem_ctrl.allow_wr = 1'b1;
                        allow_cnt_in      = allow_cnt_ff + 1'b1;
                     end
                  end
                  madf_pkg::KIND_DENY: begin
                     rsp_valid_in    = 1'b1;
                     rsp_filtered_in = 1'b0;
                     rsp_status_in   = deny_full;
                     if (!deny_full) begin
                        mem_ctrl.deny_wr = 1'b1;
                        deny_cnt_in      = deny_cnt_ff + 1'b1;
                     end
                  end
                  madf_pkg::KIND_CLEAR: begin
                     rsp_valid_in    = 1'b1;
                     rsp_filtered_in = 1'b0;
                     rsp_status_in   = 1'b0;
                     allow_cnt_in    = '0;
                     deny_cnt_in     = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_ctrl.rd_en = 1'b1;
            cmp_vld_in     = 1'b1;
            cmp_idx_in     = scan_idx_ff;
            allow_hit_in   = allow_any;
            deny_hit_in    = deny_any;
            scan_idx_in    = scan_idx_ff + 1'b1;
            if (scan_idx_ff == IDX_W'(LIST_DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmp_vld_in      = 1'b0;
            rsp_valid_in    = 1'b1;
            rsp_filtered_in = deny_any || ((allow_cnt_ff != '0) && !allow_any);
            rsp_status_in   = 1'b0;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         allow_cnt_ff <= '0;
         deny_cnt_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         allow_cnt_ff <= allow_cnt_in;
         deny_cnt_ff  <= deny_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff          <= mac_in;
      scan_idx_ff     <= scan_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      allow_hit_ff    <= allow_hit_in;
      deny_hit_ff     <= deny_hit_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_status   = rsp_status_ff;
endmodule
`default_nettype wire

FILE: rtl/mac_allow_deny_filter.sv
// Channel  Ports                                      Direction
// req      req_valid/req_ready, req_kind, req_mac     in
// rsp      rsp_valid/rsp_ready, rsp_filtered, rsp_status  out
//
// Add and clear items: result valid in the cycle after accept.
// Check items: SCAN reads both list memories in parallel, one entry per cycle,
// then DRAIN registers the result.
// Synchronous reset empties both lists; no clearing pass.
// A waiting result stalls new items; writes happen only between scans.
`default_nettype none
module mac_allow_deny_filter #(
   parameter int LIST_DEPTH = madf_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [madf_pkg::KIND_W-1:0] req_kind,
   input  wire logic [madf_pkg::MAC_W-1:0]  req_mac,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_filtered,
   output      logic                        rsp_status
);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   madf_pkg::mem_ctrl_type     mem_ctrl;
   logic [IDX_W-1:0]           wr_addr;
   logic [IDX_W-1:0]           rd_addr;
   logic [madf_pkg::MAC_W-1:0] allow_rd_data;
   logic [madf_pkg::MAC_W-1:0] deny_rd_data;

   madf_ctrl #(
      .LIST_DEPTH(LIST_DEPTH),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_mac      (req_mac),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_status   (rsp_status),
      .mem_ctrl     (mem_ctrl),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .allow_rd_data(allow_rd_data),
      .deny_rd_data (deny_rd_data)
   );

   madf_list_mem #(
      .DEPTH(LIST_DEPTH),
      .IDX_W(IDX_W)
   ) u_allow_mem (
      .clock  (clock),
      .wr_en  (mem_ctrl.allow_wr),
      .wr_addr(wr_addr),
      .wr_data(req_mac),
      .rd_en  (mem_ctrl.rd_en),
      .rd_addr(rd_addr),
      .rd_data(allow_rd_data)
   );

   madf_list_mem #(
      .DEPTH(LIST_DEPTH),
      .IDX_W(IDX_W)
   ) u_deny_mem (
      .clock  (clock),
      .wr_en  (mem_ctrl.deny_wr),
      .wr_addr(wr_addr),
      .wr_data(req_mac),
      .rd_en  (mem_ctrl.rd_en),
      .rd_addr(rd_addr),
      .rd_data(deny_rd_data)
   );

`ifndef SYNTH
   a_no_wr_during_scan: assert property (@(posedge clock) disable iff (reset)
      (mem_ctrl.allow_wr || mem_ctrl.deny_wr) |-> !mem_ctrl.rd_en)
      else $error("list write during scan");

   a_one_list_wr: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctrl.allow_wr && mem_ctrl.deny_wr))
      else $error("both lists written at once");

   a_check_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == madf_pkg::KIND_CHECK)
      |=> (!req_ready && !rsp_valid))
      else $error("check item did not start a scan");

   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_filtered)
      else $error("full status with filtered set");
`endif
endmodule
`default_nettype wire
